// ===== rtl/core/rbs_pkg.sv =====
package rbs_pkg;

    // Field widths of the transactions and of the limit register.
    localparam int TOTAL_W = 32;
    localparam int RETRY_W = 4;
    localparam int IDX_W   = 5;
    localparam int LIMIT_W = 20;
    localparam int IVL_W   = 32;

    // Default retry saturation point.
    localparam int MAX_RETRIES_DEF = 15;

    // Value of the lower limit after reset, in microseconds.
    localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RESET = LIMIT_W'(300000);

    // The restoring divider retires one quotient bit per cycle.
    localparam int DIV_STEPS = TOTAL_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             div_step;
        logic             init_emit;
        logic             emit;
        logic [IDX_W-1:0] num;
        logic [IDX_W-1:0] index;
        logic             last;
    } rbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } rbs_stat_t;

endpackage

// ===== rtl/core/rbs_if.sv =====
// Input channel: one budget and retry count per transaction.
interface rbs_in_if
    import rbs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_usec;
    logic [RETRY_W-1:0] retry_count;

    modport source (output valid, output total_usec, output retry_count, input ready);
    modport sink   (input valid, input total_usec, input retry_count, output ready);
endinterface

// Output channel: one retry interval per transfer, with a run of intervals per transaction.
interface rbs_out_if
    import rbs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IVL_W-1:0] interval_usec;
    logic [IDX_W-1:0] interval_index;
    logic             last;

    modport source (output valid, output interval_usec, output interval_index,
                    output last, input ready);
    modport sink   (input valid, input interval_usec, input interval_index,
                    input last, output ready);
endinterface

// ===== rtl/core/rbs_ctrl.sv =====
module rbs_ctrl
    import rbs_pkg::*;
#(
    parameter int MAX_RETRIES = MAX_RETRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [RETRY_W-1:0] retry_count,
    output logic               in_ready,
    input  rbs_stat_t          stat,
    output rbs_cmd_t           cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_INIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] retry_sat;

    // Saturate the retry count; the run has one more interval than retries.
    always_comb
    begin
        retry_sat = IDX_W'(retry_count);
        if (retry_sat > IDX_W'(MAX_RETRIES))
        begin
            retry_sat = IDX_W'(MAX_RETRIES);
        end
    end

    // Sequencer: load, divide, set up the doubling, then emit intervals.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.init_emit = 1'b0;
        cmd.emit      = 1'b0;
        cmd.num       = retry_sat + IDX_W'(1);
        cmd.index     = idx_reg;
        cmd.last      = (idx_reg == n_reg);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    n_next     = retry_sat + IDX_W'(1);
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init_emit = 1'b1;
                idx_next      = IDX_W'(1);
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                    if (idx_reg == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
        end
    end

endmodule

// ===== rtl/core/rbs_datapath.sv =====
module rbs_datapath
    import rbs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data,
    input  logic [TOTAL_W-1:0] total_usec,
    input  rbs_cmd_t           cmd,
    output rbs_stat_t          stat,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [IVL_W-1:0]   interval_usec,
    output logic [IDX_W-1:0]   interval_index,
    output logic               last
);

    logic [LIMIT_W-1:0] lower_limit_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] divisor_reg;
    logic [TOTAL_W-1:0] rem_reg;
    logic [TOTAL_W-1:0] quo_reg;
    logic [TOTAL_W-1:0] step_reg, step_next;
    logic               step_ovf_reg, step_ovf_next;
    logic [TOTAL_W-1:0] remain_reg, remain_next;
    logic               spent_reg, spent_next;
    logic               out_valid_reg;
    logic [IVL_W-1:0]   ivl_reg, ivl_next;
    logic [IDX_W-1:0]   index_reg;
    logic               last_reg;

    logic [TOTAL_W:0]   partial;
    logic [TOTAL_W:0]   trial;
    logic [TOTAL_W-1:0] limit_ext;

    // Lower limit register; the user must write it only while the block is idle, the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_limit_reg <= LOWER_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            lower_limit_reg <= cfg_wr_data;
        end
    end

    // One restoring division step: shift in the next dividend bit and trial subtract.
    assign partial = {rem_reg, quo_reg[TOTAL_W-1]};
    assign trial   = partial - {1'b0, divisor_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            total_reg   <= total_usec;
            quo_reg     <= total_usec;
            rem_reg     <= '0;
            divisor_reg <= ~({TOTAL_W{1'b1}} << cmd.num);
        end
        else if (cmd.div_step)
        begin
            if (!trial[TOTAL_W])
            begin
                rem_reg <= trial[TOTAL_W-1:0];
                quo_reg <= {quo_reg[TOTAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= partial[TOTAL_W-1:0];
                quo_reg <= {quo_reg[TOTAL_W-2:0], 1'b0};
            end
        end
    end

    // Next interval from the doubling step, the lower limit and the budget left.
    assign limit_ext = TOTAL_W'(lower_limit_reg);

    always_comb
    begin
        ivl_next      = '0;
        remain_next   = remain_reg;
        spent_next    = spent_reg;
        step_next     = step_reg << 1;
        step_ovf_next = step_ovf_reg | step_reg[TOTAL_W-1];
        if (spent_reg)
        begin
            ivl_next = '0;
        end
        else if (!step_ovf_reg && (step_reg < limit_ext))
        begin
            ivl_next = IVL_W'(limit_ext);
            if (limit_ext >= remain_reg)
            begin
                spent_next = 1'b1;
            end
            else
            begin
                remain_next = remain_reg - limit_ext;
            end
        end
        else if (!step_ovf_reg && (remain_reg > step_reg))
        begin
            ivl_next    = IVL_W'(step_reg);
            remain_next = remain_reg - step_reg;
        end
        else
        begin
            ivl_next   = IVL_W'(remain_reg);
            spent_next = 1'b1;
        end
    end

    // Schedule state: the quotient seeds the doubling step.
    always_ff @(posedge clk)
    begin
        if (cmd.init_emit)
        begin
            step_reg     <= quo_reg;
            step_ovf_reg <= 1'b0;
            remain_reg   <= total_reg;
            spent_reg    <= (total_reg == '0);
        end
        else if (cmd.emit)
        begin
            step_reg     <= step_next;
            step_ovf_reg <= step_ovf_next;
            remain_reg   <= remain_next;
            spent_reg    <= spent_next;
        end
    end

    // Output register holds one result until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            ivl_reg   <= ivl_next;
            index_reg <= cmd.index;
            last_reg  <= cmd.last;
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign interval_usec  = ivl_reg;
    assign interval_index = index_reg;
    assign last           = last_reg;

endmodule

// ===== rtl/core/retry_backoff_schedule_unit.sv =====
// An input transaction is loaded, then divided in 32 restoring divide steps, one quotient
// bit per cycle, then the doubling is set up before the first interval is emitted.
// A new transaction is taken only once the last interval of the run has been emitted.
// Intervals then leave one per cycle from a single output register while the sink is ready.
// Reset: rst_n is asynchronous, active low; it idles the controller, empties the
// output register and sets the lower limit to 300000 microseconds.
module retry_backoff_schedule_unit
    import rbs_pkg::*;
#(
    parameter int MAX_RETRIES = MAX_RETRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    rbs_in_if.sink             in,
    rbs_out_if.source          out,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data
);

    rbs_cmd_t  cmd;
    rbs_stat_t stat;

    rbs_ctrl #(
        .MAX_RETRIES (MAX_RETRIES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in.valid),
        .retry_count (in.retry_count),
        .in_ready    (in.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    rbs_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .total_usec     (in.total_usec),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (out.ready),
        .out_valid      (out.valid),
        .interval_usec  (out.interval_usec),
        .interval_index (out.interval_index),
        .last           (out.last)
    );

    // A new interval never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out.valid || out.ready))
        else $error("interval emitted over a pending result");

    // After an input transaction the block is busy with the division.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in.valid && in.ready) |=> !in.ready)
        else $error("input accepted again right after a transaction");

    // Intervals are only emitted while no input can be taken.
    a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !in.ready)
        else $error("interval emitted while idle");

    // The first interval of a run carries index one.
    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init_emit |=> (cmd.index == IDX_W'(1)))
        else $error("run does not start at index one");

endmodule
